### hdl/border_contour_tracer_macros.svh
// ---------------------------------------------------------------------------
// border_contour_tracer_macros
// Assertion macros for the border contour tracer. They expand to nothing
// when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef BORDER_CONTOUR_TRACER_MACROS_SVH
`define BORDER_CONTOUR_TRACER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define BCT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("border_contour_tracer: assertion failed");
// Next-cycle implication
`define BCT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("border_contour_tracer: assertion failed");
`else
`define BCT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BCT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hdl/bct_pkg.sv
// ---------------------------------------------------------------------------
// bct_pkg
// Shared types, codes and step tables of the border contour tracer.
// ---------------------------------------------------------------------------
package bct_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    // Request modes
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_TRACE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // Register indexes
    localparam logic [1:0] REG_WIDTH   = 2'd0;
    localparam logic [1:0] REG_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_MIN_LEN = 2'd2;

    localparam logic [18:0] MIN_LEN_RESET = 19'd1000;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_SCAN,
        S_CENTER,
        S_NPROBE,
        S_NCHK,
        S_WMARK,
        S_WPROBE,
        S_WCHK,
        S_FINISH,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [8:0]  width;
        logic [8:0]  height;
        logic [18:0] min_len;
    } t_cfg;

    typedef struct packed {
        logic [18:0] contour_length;
        logic [7:0]  start_x;
        logic [7:0]  start_y;
        logic [15:0] object_id;
        logic        scan_done;
        logic        on_contour;
    } t_result;

    // Column step of a direction, two's complement
    function automatic logic [1:0] step_dx(input logic [2:0] dir);
        logic [1:0] v;
        case (dir)
            3'd0: v = 2'b01;
            3'd1: v = 2'b01;
            3'd2: v = 2'b00;
            3'd3: v = 2'b11;
            3'd4: v = 2'b11;
            3'd5: v = 2'b11;
            3'd6: v = 2'b00;
            default: v = 2'b01;
        endcase
        return v;
    endfunction

    // Row step of a direction, two's complement
    function automatic logic [1:0] step_dy(input logic [2:0] dir);
        logic [1:0] v;
        case (dir)
            3'd0: v = 2'b00;
            3'd1: v = 2'b11;
            3'd2: v = 2'b11;
            3'd3: v = 2'b11;
            3'd4: v = 2'b00;
            3'd5: v = 2'b01;
            3'd6: v = 2'b01;
            default: v = 2'b01;
        endcase
        return v;
    endfunction

endpackage

### hdl/bct_bit_ram.sv
// ---------------------------------------------------------------------------
// bct_bit_ram
// One-bit synchronous RAM, one write port and one registered read port.
// ---------------------------------------------------------------------------
module bct_bit_ram #(
    parameter int ADDR_W = 16
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic              i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic              o_rdata
);

    logic r_mem [2**ADDR_W];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### hdl/bct_engine.sv
// ---------------------------------------------------------------------------
// bct_engine
// Request sequencer: post-reset contour map clear, pixel loads, contour map
// reads, raster scan and Moore neighbour walk over the image and contour RAMs.
// ---------------------------------------------------------------------------
module bct_engine #(
    parameter int MAX_WIDTH  = bct_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bct_pkg::DEF_MAX_HEIGHT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bct_pkg::t_cfg    i_cfg,
    input  logic             i_req_valid,
    output logic             o_req_stall,
    input  logic [1:0]       i_mode,
    input  logic [7:0]       i_pixel_x,
    input  logic [7:0]       i_pixel_y,
    input  logic             i_pixel_white,
    output logic             o_res_valid,
    input  logic             i_res_take,
    output bct_pkg::t_result o_res
);

    localparam int AXW    = (MAX_WIDTH > 256) ? 8 : $clog2(MAX_WIDTH);
    localparam int AYW    = (MAX_HEIGHT > 256) ? 8 : $clog2(MAX_HEIGHT);
    localparam int ADDR_W = AXW + AYW;

    bct_pkg::t_state  r_state, n_state;
    logic [7:0]       r_col, n_col, r_row, n_row;
    logic [7:0]       r_cx, n_cx, r_cy, n_cy;
    logic [7:0]       r_nx, n_nx, r_ny, n_ny;
    logic [2:0]       r_dir, n_dir, r_nd, n_nd, r_i, n_i;
    logic [18:0]      r_steps, n_steps, r_len, n_len, r_limit, n_limit;
    logic [15:0]      r_nobj, n_nobj;
    logic             r_rd_in, n_rd_in;
    logic [ADDR_W-1:0] r_clr, n_clr;
    bct_pkg::t_result r_res, n_res;

    logic             w_accept, w_in_store;
    logic [ADDR_W-1:0] w_in_addr, w_ctr_addr, w_nbr_addr, w_walk_addr;
    logic             w_row_end, w_col_end, w_last, w_over, w_closed;
    logic [18:0]      w_steps_inc;
    logic [17:0]      w_area;
    logic [2:0]       w_nd;
    logic [7:0]       w_bx, w_by;
    logic [1:0]       w_dx, w_dy;
    logic [9:0]       w_nx10, w_ny10;
    logic             w_out;
    logic             img_we, img_rdata, cnt_we, cnt_wdata, cnt_rdata;
    logic [ADDR_W-1:0] img_raddr, cnt_raddr, cnt_waddr;

    // Request decode
    assign w_accept   = i_req_valid && (r_state == bct_pkg::S_IDLE);
    assign w_in_store = ({5'd0, i_pixel_x} < 13'(MAX_WIDTH))
                      && ({5'd0, i_pixel_y} < 13'(MAX_HEIGHT));
    assign w_in_addr  = {i_pixel_y[AYW-1:0], i_pixel_x[AXW-1:0]};
    assign w_ctr_addr = {r_row[AYW-1:0], r_col[AXW-1:0]};
    assign w_walk_addr = {r_cy[AYW-1:0], r_cx[AXW-1:0]};

    // Scan bounds and walk bookkeeping
    assign w_row_end   = ({2'b00, r_row} + 10'd2) > {1'b0, i_cfg.height};
    assign w_col_end   = ({2'b00, r_col} + 10'd2) > {1'b0, i_cfg.width};
    assign w_last      = (r_i == 3'd7);
    assign w_steps_inc = r_steps + 19'd1;
    assign w_over      = w_steps_inc > r_limit;
    assign w_closed    = (r_nx == r_col) && (r_ny == r_row);
    assign w_area      = i_cfg.width * i_cfg.height;

    // Neighbour under probe
    assign w_nd   = (r_state == bct_pkg::S_NPROBE) ? r_i : r_dir + r_i;
    assign w_bx   = (r_state == bct_pkg::S_NPROBE) ? r_col : r_cx;
    assign w_by   = (r_state == bct_pkg::S_NPROBE) ? r_row : r_cy;
    assign w_dx   = bct_pkg::step_dx(w_nd);
    assign w_dy   = bct_pkg::step_dy(w_nd);
    assign w_nx10 = {2'b00, w_bx} + {{8{w_dx[1]}}, w_dx};
    assign w_ny10 = {2'b00, w_by} + {{8{w_dy[1]}}, w_dy};
    assign w_out  = w_nx10[9] || w_ny10[9]
                  || (w_nx10 >= {1'b0, i_cfg.width})
                  || (w_ny10 >= {1'b0, i_cfg.height});
    assign w_nbr_addr = {w_ny10[AYW-1:0], w_nx10[AXW-1:0]};

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bct_pkg::S_CLEAR: begin
                if (r_clr == '1) n_state = bct_pkg::S_IDLE;
            end
            bct_pkg::S_IDLE: begin
                if (w_accept && i_mode == bct_pkg::MODE_READ) n_state = bct_pkg::S_READ;
                if (w_accept && i_mode == bct_pkg::MODE_TRACE) n_state = bct_pkg::S_SCAN;
            end
            bct_pkg::S_READ:   n_state = bct_pkg::S_EMIT;
            bct_pkg::S_SCAN: begin
                if (w_row_end) n_state = bct_pkg::S_EMIT;
                else if (!w_col_end) n_state = bct_pkg::S_CENTER;
            end
            bct_pkg::S_CENTER: begin
                n_state = (!img_rdata && !cnt_rdata) ? bct_pkg::S_NPROBE : bct_pkg::S_SCAN;
            end
            bct_pkg::S_NPROBE: n_state = bct_pkg::S_NCHK;
            bct_pkg::S_NCHK: begin
                if (img_rdata) n_state = bct_pkg::S_WMARK;
                else if (w_last) n_state = bct_pkg::S_SCAN;
                else n_state = bct_pkg::S_NPROBE;
            end
            bct_pkg::S_WMARK:  n_state = bct_pkg::S_WPROBE;
            bct_pkg::S_WPROBE: begin
                if (!w_out) n_state = bct_pkg::S_WCHK;
                else if (w_last) n_state = bct_pkg::S_FINISH;
            end
            bct_pkg::S_WCHK: begin
                if (!img_rdata) begin
                    n_state = (w_over || w_closed) ? bct_pkg::S_FINISH : bct_pkg::S_WMARK;
                end else begin
                    n_state = w_last ? bct_pkg::S_FINISH : bct_pkg::S_WPROBE;
                end
            end
            bct_pkg::S_FINISH: n_state = bct_pkg::S_EMIT;
            bct_pkg::S_EMIT: begin
                if (i_res_take) n_state = bct_pkg::S_IDLE;
            end
            default: n_state = bct_pkg::S_IDLE;
        endcase
    end

    // RAM controls and handshake outputs
    always_comb begin
        img_we    = w_accept && (i_mode == bct_pkg::MODE_WRITE) && w_in_store;
        img_raddr = (r_state == bct_pkg::S_SCAN) ? w_ctr_addr : w_nbr_addr;
        cnt_raddr = (r_state == bct_pkg::S_IDLE) ? w_in_addr : w_ctr_addr;
        cnt_we    = (r_state == bct_pkg::S_CLEAR) || (r_state == bct_pkg::S_WMARK);
        cnt_waddr = (r_state == bct_pkg::S_CLEAR) ? r_clr : w_walk_addr;
        cnt_wdata = (r_state == bct_pkg::S_WMARK);
        o_req_stall = (r_state != bct_pkg::S_IDLE);
        o_res_valid = (r_state == bct_pkg::S_EMIT);
        o_res       = r_res;
    end

    // Datapath next values
    always_comb begin
        n_col = r_col;  n_row = r_row;  n_cx = r_cx;  n_cy = r_cy;
        n_nx = r_nx;    n_ny = r_ny;    n_dir = r_dir; n_nd = r_nd; n_i = r_i;
        n_steps = r_steps; n_len = r_len; n_limit = r_limit; n_nobj = r_nobj;
        n_rd_in = r_rd_in; n_clr = r_clr; n_res = r_res;
        case (r_state)
            bct_pkg::S_CLEAR: n_clr = r_clr + 1'b1;
            bct_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_rd_in = w_in_store;
                    n_limit = {w_area[16:0], 2'b00};
                end
            end
            bct_pkg::S_READ: begin
                n_res = '0;
                n_res.on_contour = r_rd_in && cnt_rdata;
            end
            bct_pkg::S_SCAN: begin
                if (w_row_end) begin
                    n_row = 8'(i_cfg.height - 9'd1);
                    n_col = 8'd1;
                    n_res = '0;
                    n_res.scan_done = 1'b1;
                end else if (w_col_end) begin
                    n_row = r_row + 8'd1;
                    n_col = 8'd1;
                end
            end
            bct_pkg::S_CENTER: begin
                if (!img_rdata && !cnt_rdata) n_i = 3'd0;
                else n_col = r_col + 8'd1;
            end
            bct_pkg::S_NCHK: begin
                if (img_rdata) begin
                    n_cx = r_col; n_cy = r_row; n_dir = 3'd0;
                    n_steps = '0; n_len = '0;
                end else if (w_last) begin
                    n_col = r_col + 8'd1;
                end else begin
                    n_i = r_i + 3'd1;
                end
            end
            bct_pkg::S_WMARK: begin
                n_len = r_len + 19'd1;
                n_i   = 3'd0;
            end
            bct_pkg::S_WPROBE: begin
                if (w_out) begin
                    n_i = r_i + 3'd1;
                end else begin
                    n_nx = w_nx10[7:0];
                    n_ny = w_ny10[7:0];
                    n_nd = w_nd;
                end
            end
            bct_pkg::S_WCHK: begin
                if (!img_rdata) begin
                    n_cx = r_nx; n_cy = r_ny;
                    n_dir = r_nd + 3'd6;
                    n_steps = w_steps_inc;
                end else begin
                    n_i = r_i + 3'd1;
                end
            end
            bct_pkg::S_FINISH: begin
                n_res = '0;
                n_res.contour_length = r_len;
                n_res.start_x = r_col;
                n_res.start_y = r_row;
                if (r_len > i_cfg.min_len) begin
                    n_res.object_id = r_nobj;
                    n_nobj = (r_nobj == 16'hFFFF) ? 16'd1 : r_nobj + 16'd1;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bct_pkg::S_CLEAR;
            r_col   <= 8'd1;
            r_row   <= 8'd1;
            r_nobj  <= 16'd1;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_nobj  <= n_nobj;
            r_clr   <= n_clr;
        end
    end

    // Walk and result payload
    always_ff @(posedge i_clk) begin
        r_cx <= n_cx;  r_cy <= n_cy;  r_nx <= n_nx;  r_ny <= n_ny;
        r_dir <= n_dir; r_nd <= n_nd; r_i <= n_i;
        r_steps <= n_steps; r_len <= n_len; r_limit <= n_limit;
        r_rd_in <= n_rd_in; r_res <= n_res;
    end

    bct_bit_ram #(.ADDR_W(ADDR_W)) u_image_ram (
        .i_clk   (i_clk),
        .i_we    (img_we),
        .i_waddr (w_in_addr),
        .i_wdata (i_pixel_white),
        .i_raddr (img_raddr),
        .o_rdata (img_rdata)
    );

    bct_bit_ram #(.ADDR_W(ADDR_W)) u_contour_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

endmodule

### hdl/border_contour_tracer.sv
// ---------------------------------------------------------------------------
// border_contour_tracer
// Moore neighbour contour tracer over a one-bit image held in block RAM.
//
// Request channel (i_in_valid / o_in_stall): mode 0 loads one pixel, mode 1
// traces the next contour, mode 2 reads one contour map bit; mode 3 is
// dropped. Result channel (o_out_valid / i_out_stall) carries one word for
// modes 1 and 2 and none for mode 0.
// Pixel loads are taken one per cycle, back to back. A map read goes through
// the read and emit states to its result word. A trace scans column by
// column with a centre test and neighbour probes, and each walk step marks
// the pixel and then probes neighbours, skipping off-image ones unread;
// every other probe is one registered read of the single image RAM port.
// Configuration writes (i_cfg_valid / o_cfg_ready) are always taken and
// belong only to idle periods.
// After reset the contour map is swept to zero, one entry a cycle
// (2**(address bits) entries, 65536 by default); o_in_stall is high then.
// When the receiver stalls, the result is held in the output register and
// the next request is taken; the word after that waits in the sequencer.
// ---------------------------------------------------------------------------
module border_contour_tracer #(
    parameter int MAX_WIDTH  = bct_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bct_pkg::DEF_MAX_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [18:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_pixel_x,
    input  logic [7:0]  i_pixel_y,
    input  logic        i_pixel_white,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [18:0] o_contour_length,
    output logic [7:0]  o_start_x,
    output logic [7:0]  o_start_y,
    output logic [15:0] o_object_id,
    output logic        o_scan_done,
    output logic        o_on_contour
);

    `include "border_contour_tracer_macros.svh"

    localparam int         WMAX   = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
    localparam int         HMAX   = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;
    localparam logic [8:0] WMAX_V = 9'(WMAX);
    localparam logic [8:0] HMAX_V = 9'(HMAX);

    bct_pkg::t_cfg    r_cfg, n_cfg;
    bct_pkg::t_result r_out, w_res;
    logic             r_out_valid;
    logic             w_res_valid, w_take;
    logic [8:0]       w_dim;

    assign o_cfg_ready = 1'b1;
    assign w_dim       = i_cfg_data[8:0];

    // Saturate dimensions into range on write
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                bct_pkg::REG_WIDTH: begin
                    n_cfg.width = (w_dim < 9'd3) ? 9'd3 : (w_dim > WMAX_V) ? WMAX_V : w_dim;
                end
                bct_pkg::REG_HEIGHT: begin
                    n_cfg.height = (w_dim < 9'd3) ? 9'd3 : (w_dim > HMAX_V) ? HMAX_V : w_dim;
                end
                bct_pkg::REG_MIN_LEN: n_cfg.min_len = i_cfg_data;
                default: ;
            endcase
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width   <= WMAX_V;
            r_cfg.height  <= HMAX_V;
            r_cfg.min_len <= bct_pkg::MIN_LEN_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Output register: load when empty or being taken
    assign w_take = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_res_valid) begin
            r_out <= w_res;
        end
    end

    bct_engine #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_req_valid   (i_in_valid),
        .o_req_stall   (o_in_stall),
        .i_mode        (i_mode),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .i_pixel_white (i_pixel_white),
        .o_res_valid   (w_res_valid),
        .i_res_take    (w_take),
        .o_res         (w_res)
    );

    assign o_out_valid      = r_out_valid;
    assign o_contour_length = r_out.contour_length;
    assign o_start_x        = r_out.start_x;
    assign o_start_y        = r_out.start_y;
    assign o_object_id      = r_out.object_id;
    assign o_scan_done      = r_out.scan_done;
    assign o_on_contour     = r_out.on_contour;

    // Checks
    `BCT_ASSERT_NXT(a_res_loaded, i_clk, i_rst_n, w_res_valid && w_take, o_out_valid)
    `BCT_ASSERT_IMP(a_done_empty, i_clk, i_rst_n, o_out_valid && o_scan_done, o_contour_length == 19'd0 && o_object_id == 16'd0)
    `BCT_ASSERT_IMP(a_read_word, i_clk, i_rst_n, o_out_valid && o_on_contour, !o_scan_done && o_contour_length == 19'd0)

endmodule

### dv/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the border contour tracer. Loads images pixel by
// pixel, issues trace and map-read requests and checks every result word
// against an in-bench model of the scan and the Moore neighbour walk.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int STORE_W = 256;

    const int STEP_X [8] = '{1, 1, 0, -1, -1, -1, 0, 1};
    const int STEP_Y [8] = '{0, -1, -1, -1, 0, 1, 1, 1};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [18:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_mode = '0;
    logic [7:0]  i_pixel_x = '0;
    logic [7:0]  i_pixel_y = '0;
    logic        i_pixel_white = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [18:0] o_contour_length;
    logic [7:0]  o_start_x;
    logic [7:0]  o_start_y;
    logic [15:0] o_object_id;
    logic        o_scan_done;
    logic        o_on_contour;

    border_contour_tracer i_dut (.*);

    // Model state
    bit          image_white [0:65535];
    bit          traced [0:65535];
    int unsigned img_w = 256, img_h = 256, min_len = 1000;
    int unsigned scan_col = 1, scan_row = 1, next_id = 1;

    bct_pkg::t_result expected_words [$];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("tb: FAIL");
        $finish;
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        i_out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // Compare each accepted word with the oldest expectation
    always @(posedge i_clk) begin
        bct_pkg::t_result e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                $error("unexpected result word");
                errors++;
            end else begin
                e = expected_words.pop_front();
                if (o_contour_length !== e.contour_length) begin
                    $error("contour_length exp %0d got %0d", e.contour_length, o_contour_length);
                    errors++;
                end
                if (o_start_x !== e.start_x) begin
                    $error("start_x exp %0d got %0d", e.start_x, o_start_x);
                    errors++;
                end
                if (o_start_y !== e.start_y) begin
                    $error("start_y exp %0d got %0d", e.start_y, o_start_y);
                    errors++;
                end
                if (o_object_id !== e.object_id) begin
                    $error("object_id exp %0d got %0d", e.object_id, o_object_id);
                    errors++;
                end
                if (o_scan_done !== e.scan_done) begin
                    $error("scan_done exp %0d got %0d", e.scan_done, o_scan_done);
                    errors++;
                end
                if (o_on_contour !== e.on_contour) begin
                    $error("on_contour exp %0d got %0d", e.on_contour, o_on_contour);
                    errors++;
                end
            end
        end
    end

    function automatic bit is_black(int x, int y);
        if (x < 0 || y < 0 || x >= int'(img_w) || y >= int'(img_h)) return 1'b0;
        return !image_white[y * STORE_W + x];
    endfunction

    function automatic bit is_border_start(int x, int y);
        if (!is_black(x, y) || traced[y * STORE_W + x]) return 1'b0;
        for (int dy = -1; dy <= 1; dy++)
            for (int dx = -1; dx <= 1; dx++)
                if ((dx != 0 || dy != 0) && !is_black(x + dx, y + dy)) return 1'b1;
        return 1'b0;
    endfunction

    // Follow the contour from its start, marking every visited pixel
    function automatic int unsigned walk_contour(int sx, int sy);
        int cx, cy, nx, ny;
        int unsigned dir, steps, len, lim, nd;
        bit found;
        cx = sx;
        cy = sy;
        dir = 0;
        steps = 0;
        len = 0;
        lim = 4 * img_w * img_h;
        do begin
            traced[cy * STORE_W + cx] = 1'b1;
            len++;
            found = 1'b0;
            for (int i = 0; i < 8; i++) begin
                if (!found) begin
                    nd = (dir + i) & 7;
                    nx = cx + STEP_X[nd];
                    ny = cy + STEP_Y[nd];
                    if (is_black(nx, ny)) begin
                        cx = nx;
                        cy = ny;
                        dir = (nd + 6) & 7;
                        found = 1'b1;
                    end
                end
            end
            if (!found) break;
            steps++;
            if (steps > lim) break;
        end while (!(cx == sx && cy == sy));
        return len & 32'h7FFFF;
    endfunction

    // Resume the raster scan and trace the next border found
    function automatic bct_pkg::t_result trace_next();
        bct_pkg::t_result r;
        int unsigned row, col, len;
        r = '0;
        r.scan_done = 1'b1;
        row = scan_row;
        col = scan_col;
        while (row + 2 <= img_h) begin
            while (col + 2 <= img_w) begin
                if (is_border_start(col, row)) begin
                    scan_col = col;
                    scan_row = row;
                    len = walk_contour(col, row);
                    r.contour_length = len[18:0];
                    r.start_x = col[7:0];
                    r.start_y = row[7:0];
                    r.scan_done = 1'b0;
                    if (len > min_len) begin
                        r.object_id = next_id[15:0];
                        next_id = (next_id >= 65535) ? 1 : next_id + 1;
                    end
                    return r;
                end
                col++;
            end
            row++;
            col = 1;
        end
        scan_row = (img_h - 1) & 8'hFF;
        scan_col = 1;
        return r;
    endfunction

    function automatic void predict_item(logic [1:0] mode, logic [7:0] x, logic [7:0] y,
                                         logic white);
        bct_pkg::t_result r;
        r = '0;
        case (mode)
            bct_pkg::MODE_WRITE: image_white[y * STORE_W + x] = white;
            bct_pkg::MODE_READ: begin
                r.on_contour = traced[y * STORE_W + x];
                expected_words.push_back(r);
            end
            bct_pkg::MODE_TRACE: expected_words.push_back(trace_next());
            default: ;
        endcase
    endfunction

    // Send one request word, with an optional random gap before it
    task automatic send_word(logic [1:0] mode, logic [7:0] x, logic [7:0] y, logic white);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_mode        <= mode;
        i_pixel_x     <= x;
        i_pixel_y     <= y;
        i_pixel_white <= white;
        do @(posedge i_clk); while (o_in_stall);
        predict_item(mode, x, y, white);
    endtask

    // Drop valid and wait for every expected word, then let the block settle
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    function automatic int unsigned clamp_dim(int unsigned v);
        if (v < 3) return 3;
        if (v > 256) return 256;
        return v;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [18:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            bct_pkg::REG_WIDTH:   img_w = clamp_dim(data & 19'h1FF);
            bct_pkg::REG_HEIGHT:  img_h = clamp_dim(data & 19'h1FF);
            bct_pkg::REG_MIN_LEN: min_len = data;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Load every pixel of the image in use, black with the given percentage
    task automatic load_image(int black_pct);
        for (int y = 0; y < int'(img_h); y++)
            for (int x = 0; x < int'(img_w); x++)
                send_word(bct_pkg::MODE_WRITE, 8'(x), 8'(y),
                          $urandom_range(99) >= black_pct);
    endtask

    // Widest strip: saturated width, minimum height, threshold at maximum
    task automatic test_wide_strip();
        write_reg(bct_pkg::REG_WIDTH, 19'd511);
        write_reg(bct_pkg::REG_HEIGHT, 19'd0);
        write_reg(bct_pkg::REG_MIN_LEN, 19'h7FFFF);
        load_image(50);
        repeat (12) send_word(bct_pkg::MODE_TRACE, 8'd0, 8'd0, 1'b0);
        send_word(bct_pkg::MODE_READ, 8'd255, 8'd1, 1'b0);
        drain();
    endtask

    // Isolated pixel, closed square, interior pixel, edge reads, unused mode
    task automatic test_directed();
        write_reg(bct_pkg::REG_WIDTH, 19'd7);
        write_reg(bct_pkg::REG_HEIGHT, 19'd7);
        write_reg(bct_pkg::REG_MIN_LEN, 19'd0);
        load_image(0);
        send_word(bct_pkg::MODE_WRITE, 8'd1, 8'd2, 1'b0);
        for (int y = 2; y <= 4; y++)
            for (int x = 3; x <= 5; x++)
                send_word(bct_pkg::MODE_WRITE, 8'(x), 8'(y), 1'b0);
        send_word(bct_pkg::MODE_WRITE, 8'd255, 8'd255, 1'b1);
        send_word(MODE_UNUSED, 8'd1, 8'd2, 1'b1);
        repeat (4) send_word(bct_pkg::MODE_TRACE, 8'd255, 8'd255, 1'b1);
        send_word(bct_pkg::MODE_READ, 8'd1, 8'd2, 1'b0);
        send_word(bct_pkg::MODE_READ, 8'd4, 8'd3, 1'b0);
        send_word(bct_pkg::MODE_READ, 8'd0, 8'd0, 1'b0);
        send_word(bct_pkg::MODE_READ, 8'd255, 8'd255, 1'b1);
        drain();
    endtask

    // Growing images: scan resumes at each new height; random request mix
    task automatic test_random_images();
        int heights [9] = '{4, 6, 8, 10, 12, 14, 16, 18, 20};
        int r;
        for (int p = 0; p < 9; p++) begin
            case (p % 5)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 80; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 80; end
                3: begin send_idle_pct = 15; stall_pct = 15; end
                default: begin send_idle_pct = 0; stall_pct = 0; end
            endcase
            write_reg(bct_pkg::REG_WIDTH, (p == 8) ? 19'd3 : 19'($urandom_range(6, 3)));
            write_reg(bct_pkg::REG_HEIGHT, 19'(heights[p]));
            case ($urandom_range(3))
                0: write_reg(bct_pkg::REG_MIN_LEN, 19'd0);
                1: write_reg(bct_pkg::REG_MIN_LEN, 19'($urandom_range(12)));
                2: write_reg(bct_pkg::REG_MIN_LEN, bct_pkg::MIN_LEN_RESET);
                default: write_reg(bct_pkg::REG_MIN_LEN, 19'h7FFFF);
            endcase
            load_image($urandom_range(70, 30));
            repeat (40) begin
                r = $urandom_range(99);
                if (r < 35)
                    send_word(bct_pkg::MODE_TRACE, 8'($urandom), 8'($urandom), 1'($urandom));
                else if (r < 50)
                    send_word(bct_pkg::MODE_READ, 8'($urandom), 8'($urandom), 1'($urandom));
                else if (r < 65)
                    send_word(bct_pkg::MODE_READ, 8'($urandom_range(img_w - 1)),
                              8'($urandom_range(img_h - 1)), 1'($urandom));
                else if (r < 92)
                    send_word(bct_pkg::MODE_WRITE, 8'($urandom_range(img_w - 1)),
                              8'($urandom_range(img_h - 1)), 1'($urandom));
                else if (r < 97)
                    send_word(bct_pkg::MODE_WRITE, 8'($urandom), 8'($urandom), 1'($urandom));
                else
                    send_word(MODE_UNUSED, 8'($urandom), 8'($urandom), 1'($urandom));
            end
            drain();
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_wide_strip();
        test_directed();
        test_random_images();
        if (errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
